// ===== sv/sctm_pkg.sv =====
`default_nettype none

package sctm_pkg;

	localparam int CFG_W  = 7;
	localparam int CH_W   = 6;
	localparam int TIME_W = 64;

	localparam logic [CFG_W-1:0] ACTIVE_RESET = 7'd64;

	localparam logic CMD_SET    = 1'b0;
	localparam logic CMD_CANCEL = 1'b1;

	typedef struct packed {
		logic load;
		logic decide;
		logic scan;
		logic finish;
		logic respond;
	} sctm_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic scan_done;
	} sctm_status_t;

endpackage

`default_nettype wire

// ===== sv/shared_comparator_timer_multiplexer.sv =====
`default_nettype none

// Shared comparator timer multiplexer. A request is taken when start is high
// and busy is low; one result follows, shown for exactly one cycle with done
// high, and the receiver cannot stall it. A request that needs no search goes
// from the decide state straight to the response state. A request that clears
// the armed timer (cancel of the armed channel, or a set whose armed deadline
// is already past) searches the deadline memory one entry per cycle through
// its single read port over entries 0..n-1, where n is active_channels clamped
// to 1..CHANNELS, then passes the drain and finish states before done. The
// deadline memory needs no clearing pass after reset. cfg_ready is always
// high; write active_channels only while busy is low.

module shared_comparator_timer_multiplexer #(
	parameter int CHANNELS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          cmd,
	input  wire logic [sctm_pkg::CH_W-1:0]     channel,
	input  wire logic [sctm_pkg::TIME_W-1:0]   deadline,
	input  wire logic [sctm_pkg::TIME_W-1:0]   now,
	output logic                               done,
	output logic                               missed,
	output logic                               expired,
	output logic                               armed,
	output logic      [sctm_pkg::TIME_W-1:0]   compare_value,
	output logic      [sctm_pkg::CH_W-1:0]     compare_channel,
	output logic                               kick,
	output logic      [sctm_pkg::CH_W-1:0]     kick_channel,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [sctm_pkg::CFG_W-1:0]    cfg_data
);

	sctm_pkg::sctm_cmd_t    ctl;
	sctm_pkg::sctm_status_t st;

	assign cfg_ready = 1'b1;
	assign done      = ctl.respond;

	sctm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.ctl    (ctl),
		.busy   (busy)
	);

	sctm_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.st              (st),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.channel         (channel),
		.deadline        (deadline),
		.now             (now),
		.missed          (missed),
		.expired         (expired),
		.armed           (armed),
		.compare_value   (compare_value),
		.compare_channel (compare_channel),
		.kick            (kick),
		.kick_channel    (kick_channel)
	);

endmodule

`default_nettype wire

// ===== sv/sctm_ram.sv =====
`default_nettype none

module sctm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/sctm_ctrl.sv =====
`default_nettype none

module sctm_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire sctm_pkg::sctm_status_t st,
	output sctm_pkg::sctm_cmd_t        ctl,
	output logic                       busy
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECIDE = 6'b000010,
		S_SCAN   = 6'b000100,
		S_DRAIN  = 6'b001000,
		S_FIN    = 6'b010000,
		S_RESP   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				ctl.load = start;
				if (start) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				ctl.decide = 1'b1;
				state_d    = st.need_scan ? S_SCAN : S_RESP;
			end
			S_SCAN: begin
				ctl.scan = 1'b1;
				if (st.scan_done) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				ctl.finish = 1'b1;
				state_d    = S_RESP;
			end
			S_RESP: begin
				ctl.respond = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

`ifndef ASSERT_OFF
	a_resp_frees: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.respond |=> !busy)
		else $error("request still busy after response");
`endif

endmodule

`default_nettype wire

// ===== sv/sctm_dp.sv =====
`default_nettype none

module sctm_dp #(
	parameter int CHANNELS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sctm_pkg::sctm_cmd_t           ctl,
	output sctm_pkg::sctm_status_t             st,
	input  wire logic                          cfg_we,
	input  wire logic [sctm_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                          cmd,
	input  wire logic [sctm_pkg::CH_W-1:0]     channel,
	input  wire logic [sctm_pkg::TIME_W-1:0]   deadline,
	input  wire logic [sctm_pkg::TIME_W-1:0]   now,
	output logic                               missed,
	output logic                               expired,
	output logic                               armed,
	output logic      [sctm_pkg::TIME_W-1:0]   compare_value,
	output logic      [sctm_pkg::CH_W-1:0]     compare_channel,
	output logic                               kick,
	output logic      [sctm_pkg::CH_W-1:0]     kick_channel
);

	localparam int IW = $clog2(CHANNELS);
	localparam int CW = $clog2(CHANNELS + 1);
	localparam int LW = (CW > sctm_pkg::CFG_W) ? CW : sctm_pkg::CFG_W;
	localparam logic [sctm_pkg::TIME_W-1:0] IDLE_DL = '1;

	// request registers
	logic                        cmd_q;
	logic [sctm_pkg::CH_W-1:0]   ch_q;
	logic [sctm_pkg::TIME_W-1:0] dl_q;
	logic [sctm_pkg::TIME_W-1:0] now_q;

	// comparator state
	logic                        armed_q;
	logic [IW-1:0]               armed_ch_q;
	logic [sctm_pkg::TIME_W-1:0] cmp_q;
	logic                        missed_q;
	logic                        expired_q;
	logic                        kick_q;
	logic [IW-1:0]               kick_ch_q;

	logic [sctm_pkg::CFG_W-1:0]  cfg_q;
	logic [CHANNELS-1:0]         ent_vld_q;

	// scan
	logic [IW-1:0]               rd_cnt_q;
	logic                        vld_s1;
	logic [IW-1:0]               idx_s1;
	logic                        ev_s1;
	logic [sctm_pkg::TIME_W-1:0] lowest_q;
	logic [IW-1:0]               best_q;
	logic                        found_q;

	logic [sctm_pkg::TIME_W-1:0] rdata;
	logic [sctm_pkg::TIME_W-1:0] scan_val;
	logic [LW-1:0]               cfg_ext;
	logic [LW-1:0]               n_scan;
	logic [IW-1:0]               scan_last;
	logic [IW-1:0]               ch_idx;
	logic                        in_range;
	logic                        is_set;
	logic                        is_cancel;
	logic                        was_armed;
	logic                        take;
	logic                        late;
	logic                        set_keep;
	logic                        clear_ent;

	always_comb begin
		cfg_ext = LW'(cfg_q);
		priority if (cfg_ext == '0) begin
			n_scan = LW'(1);
		end else if (cfg_ext > LW'(CHANNELS)) begin
			n_scan = LW'(CHANNELS);
		end else begin
			n_scan = cfg_ext;
		end
	end

	assign scan_last = IW'(n_scan - LW'(1));

	assign ch_idx    = IW'(ch_q);
	assign in_range  = (LW'(ch_q) < LW'(CHANNELS));
	assign is_set    = in_range && (cmd_q == sctm_pkg::CMD_SET);
	assign is_cancel = in_range && (cmd_q == sctm_pkg::CMD_CANCEL);
	assign was_armed = armed_q && (armed_ch_q == ch_idx);
	assign take      = !armed_q || was_armed || (dl_q < cmp_q);
	assign late      = (dl_q < now_q);
	assign set_keep  = is_set && !(take && late);
	assign clear_ent = (is_set && take && late) || is_cancel;

	assign st.need_scan = (is_set && take && late) || (is_cancel && was_armed);
	assign st.scan_done = (rd_cnt_q == scan_last);

	sctm_ram #(
		.WIDTH (sctm_pkg::TIME_W),
		.DEPTH (CHANNELS)
	) u_ram (
		.clk   (clk),
		.we    (ctl.decide && set_keep),
		.waddr (ch_idx),
		.wdata (dl_q),
		.re    (ctl.scan),
		.raddr (rd_cnt_q),
		.rdata (rdata)
	);

	assign scan_val = ev_s1 ? rdata : IDLE_DL;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			ch_q  <= channel;
			dl_q  <= deadline;
			now_q <= now;
		end
		if (ctl.scan) begin
			idx_s1 <= rd_cnt_q;
			ev_s1  <= ent_vld_q[rd_cnt_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q    <= 1'b0;
			armed_ch_q <= '0;
			cmp_q      <= '0;
			missed_q   <= 1'b0;
			expired_q  <= 1'b0;
			kick_q     <= 1'b0;
			kick_ch_q  <= '0;
			cfg_q      <= sctm_pkg::ACTIVE_RESET;
			ent_vld_q  <= '0;
			rd_cnt_q   <= '0;
			vld_s1     <= 1'b0;
			lowest_q   <= IDLE_DL;
			best_q     <= '0;
			found_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_data;
			end
			if (ctl.load) begin
				missed_q  <= 1'b0;
				expired_q <= 1'b0;
				kick_q    <= 1'b0;
				kick_ch_q <= '0;
			end
			if (ctl.decide) begin
				rd_cnt_q <= '0;
				lowest_q <= IDLE_DL;
				best_q   <= '0;
				found_q  <= 1'b0;
				if (set_keep) begin
					ent_vld_q[ch_idx] <= 1'b1;
				end
				if (clear_ent) begin
					ent_vld_q[ch_idx] <= 1'b0;
				end
				if (is_set && take) begin
					armed_q    <= 1'b1;
					armed_ch_q <= ch_idx;
					cmp_q      <= dl_q;
					missed_q   <= late;
				end
				if (is_cancel) begin
					expired_q <= was_armed && (now_q >= cmp_q);
				end
			end
			vld_s1 <= ctl.scan;
			if (ctl.scan) begin
				rd_cnt_q <= rd_cnt_q + IW'(1);
			end
			if (vld_s1 && (scan_val < lowest_q)) begin
				lowest_q <= scan_val;
				best_q   <= idx_s1;
				found_q  <= 1'b1;
			end
			if (ctl.finish) begin
				armed_q <= found_q;
				if (found_q) begin
					armed_ch_q <= best_q;
					cmp_q      <= lowest_q;
					if (lowest_q < now_q) begin
						kick_q    <= 1'b1;
						kick_ch_q <= best_q;
					end
				end
			end
		end
	end

	assign missed          = missed_q;
	assign expired         = expired_q;
	assign armed           = armed_q;
	assign compare_value   = armed_q ? cmp_q : '0;
	assign compare_channel = armed_q ? sctm_pkg::CH_W'(armed_ch_q) : '0;
	assign kick            = kick_q;
	assign kick_channel    = kick_q ? sctm_pkg::CH_W'(kick_ch_q) : '0;

`ifndef ASSERT_OFF
	a_s1_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(ctl.scan))
		else $error("scan stage valid without a read issued");
	a_kick_armed: assert property (@(posedge clk) disable iff (!arst_n)
		kick_q |-> armed_q)
		else $error("kick raised with comparator disarmed");
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(missed_q && expired_q))
		else $error("missed and expired both set");
`endif

endmodule

`default_nettype wire
